// File: rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 shared definitions
// Types and constants shared by the RC4 stream cipher modules.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int SBOX_SIZE   = 256;
    localparam int SBOX_AW     = $clog2(SBOX_SIZE);
    localparam int MAX_KEY_LEN = 16;
    localparam int KEY_IDX_W   = $clog2(MAX_KEY_LEN);
    localparam int KEY_LEN_W   = 5;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 64;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 8'd2;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] key_high;
        logic [CFG_DATA_W-1:0] key_low;
        logic [KEY_LEN_W-1:0]  key_length;
    } t_rc4_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_message;
        logic       last_of_message;
    } t_rc4_item;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       last_out;
    } t_rc4_result;

endpackage

// File: rtl/rc4_ram.sv
// ----------------------------------------------------------------------------
// RC4 generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rc4_core.sv
// ----------------------------------------------------------------------------
// RC4 sequencer
// Runs the key schedule and keystream generation over one permutation RAM,
// with one shared 8-bit adder stepped by a small state machine.
// ----------------------------------------------------------------------------
module rc4_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rc4_pkg::t_rc4_cfg   i_cfg,
    input  logic                i_start,
    input  rc4_pkg::t_rc4_item  i_item,
    output logic                o_idle,
    input  logic                i_out_free,
    output logic                o_res_valid,
    output rc4_pkg::t_rc4_result o_res
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FILL   = 4'd1;
    localparam logic [3:0] ST_K_RD_I = 4'd2;
    localparam logic [3:0] ST_K_RD_J = 4'd3;
    localparam logic [3:0] ST_K_WR_I = 4'd4;
    localparam logic [3:0] ST_K_WR_J = 4'd5;
    localparam logic [3:0] ST_G_RD_I = 4'd6;
    localparam logic [3:0] ST_G_RD_J = 4'd7;
    localparam logic [3:0] ST_G_WR_I = 4'd8;
    localparam logic [3:0] ST_G_WR_J = 4'd9;
    localparam logic [3:0] ST_G_RD_T = 4'd10;
    localparam logic [3:0] ST_G_OUT  = 4'd11;

    localparam int AW = rc4_pkg::SBOX_AW;
    localparam int KW = rc4_pkg::KEY_IDX_W;
    localparam int LW = rc4_pkg::KEY_LEN_W;
    localparam logic [AW-1:0] LAST_ENTRY = AW'(rc4_pkg::SBOX_SIZE - 1);
    localparam logic [LW-1:0] MAX_LEN    = LW'(rc4_pkg::MAX_KEY_LEN);

    logic [3:0]    r_state, n_state;
    logic          r_keyed, n_keyed;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_n, n_n;
    logic [KW-1:0] r_k, n_k;
    logic [7:0]    r_si, n_si;
    logic [7:0]    r_sj, n_sj;
    logic [7:0]    r_data, n_data;
    logic          r_last, n_last;

    logic [AW-1:0] w_op_a, w_op_b, w_op_c, w_sum;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [7:0]    w_wdata, w_rdata;
    logic [7:0]    w_key_byte;
    logic [LW-1:0] w_len;
    logic [2*rc4_pkg::CFG_DATA_W-1:0] w_key_all;

    always_comb begin
        w_len = i_cfg.key_length;
        if (w_len == '0) begin
            w_len = LW'(1);
        end else if (w_len > MAX_LEN) begin
            w_len = MAX_LEN;
        end
    end

    assign w_key_all  = {i_cfg.key_high, i_cfg.key_low};
    assign w_key_byte = w_key_all[{r_k, 3'b000} +: 8];

    always_comb begin
        w_op_a = r_j;
        w_op_b = w_rdata;
        w_op_c = '0;
        unique case (r_state) inside
            ST_K_RD_J: begin
                w_op_c = w_key_byte;
            end
            ST_G_RD_I: begin
                w_op_a = r_i;
                w_op_b = AW'(1);
            end
            ST_G_RD_T, ST_G_OUT: begin
                w_op_a = r_si;
                w_op_b = r_sj;
            end
            default: begin
            end
        endcase
    end

    assign w_sum = w_op_a + w_op_b + w_op_c;

    always_comb begin
        w_raddr = r_n;
        unique case (r_state) inside
            ST_K_RD_J, ST_G_RD_I, ST_G_RD_J, ST_G_RD_T, ST_G_OUT: w_raddr = w_sum;
            default: w_raddr = r_n;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_n;
        w_wdata = w_rdata;
        unique case (r_state)
            ST_FILL: begin
                w_we    = 1'b1;
                w_wdata = r_n;
            end
            ST_K_WR_I: begin
                w_we = 1'b1;
            end
            ST_K_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_si;
            end
            ST_G_WR_I: begin
                w_we    = 1'b1;
                w_waddr = r_i;
            end
            ST_G_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_si;
            end
            default: begin
            end
        endcase
    end

    rc4_ram #(
        .WIDTH(8),
        .DEPTH(rc4_pkg::SBOX_SIZE)
    ) u_sbox (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_keyed = r_keyed;
        n_i     = r_i;
        n_j     = r_j;
        n_n     = r_n;
        n_k     = r_k;
        n_si    = r_si;
        n_sj    = r_sj;
        n_data  = r_data;
        n_last  = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_data = i_item.data_byte;
                    n_last = i_item.last_of_message;
                    if (i_item.first_of_message || !r_keyed) begin
                        n_keyed = 1'b1;
                        n_n     = '0;
                        n_state = ST_FILL;
                    end else begin
                        n_state = ST_G_RD_I;
                    end
                end
            end
            ST_FILL: begin
                n_n = r_n + AW'(1);
                if (r_n == LAST_ENTRY) begin
                    n_j     = '0;
                    n_k     = '0;
                    n_state = ST_K_RD_I;
                end
            end
            ST_K_RD_I: begin
                n_state = ST_K_RD_J;
            end
            ST_K_RD_J: begin
                n_si    = w_rdata;
                n_j     = w_sum;
                n_state = ST_K_WR_I;
            end
            ST_K_WR_I: begin
                n_state = ST_K_WR_J;
            end
            ST_K_WR_J: begin
                n_n = r_n + AW'(1);
                if ({1'b0, r_k} == w_len - LW'(1)) begin
                    n_k = '0;
                end else begin
                    n_k = r_k + KW'(1);
                end
                if (r_n == LAST_ENTRY) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = ST_G_RD_I;
                end else begin
                    n_state = ST_K_RD_I;
                end
            end
            ST_G_RD_I: begin
                n_i     = w_sum;
                n_state = ST_G_RD_J;
            end
            ST_G_RD_J: begin
                n_si    = w_rdata;
                n_j     = w_sum;
                n_state = ST_G_WR_I;
            end
            ST_G_WR_I: begin
                n_sj    = w_rdata;
                n_state = ST_G_WR_J;
            end
            ST_G_WR_J: begin
                n_state = ST_G_RD_T;
            end
            ST_G_RD_T: begin
                n_state = ST_G_OUT;
            end
            ST_G_OUT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_keyed <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_n     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_keyed <= n_keyed;
            r_i     <= n_i;
            r_j     <= n_j;
            r_n     <= n_n;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_si   <= n_si;
        r_sj   <= n_sj;
        r_data <= n_data;
        r_last <= n_last;
    end

    assign o_idle            = (r_state == ST_IDLE);
    assign o_res_valid       = (r_state == ST_G_OUT) && i_out_free;
    assign o_res.cipher_byte = r_data ^ w_rdata;
    assign o_res.last_out    = r_last;

endmodule

// File: rtl/rc4_stream_cipher.sv
// A byte on a keyed stream steps through the states G_RD_I, G_RD_J, G_WR_I,
// G_WR_J, G_RD_T and G_OUT, where it waits for the output register to be
// free; no new byte is taken until the sequencer is back in IDLE. A byte that
// rekeys first makes 256 identity writes, then 256 two-read, two-write steps.
// Reset is synchronous, active low; the first byte after reset always rekeys,
// and the permutation RAM is not cleared.
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Stream interface, configuration registers and the output register around
// the RC4 sequencer.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // Fields from bit 0: data_byte[7:0].
    input  logic [7:0]                       i_s_axis_tdata,
    // Fields from bit 0: first_of_message.
    input  logic                             i_s_axis_tuser,
    input  logic                             i_s_axis_tlast,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // Fields from bit 0: cipher_byte[7:0].
    output logic [7:0]                       o_m_axis_tdata,
    output logic                             o_m_axis_tlast
);

    rc4_pkg::t_rc4_cfg    r_cfg;
    rc4_pkg::t_rc4_item   w_item;
    rc4_pkg::t_rc4_result w_res;
    rc4_pkg::t_rc4_result r_out;
    logic                 r_out_valid;
    logic                 w_idle, w_start, w_out_free, w_res_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_low    <= '0;
            r_cfg.key_high   <= '0;
            r_cfg.key_length <= rc4_pkg::KEY_LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rc4_pkg::CFG_KEY_LOW:  r_cfg.key_low    <= i_cfg_data;
                rc4_pkg::CFG_KEY_HIGH: r_cfg.key_high   <= i_cfg_data;
                rc4_pkg::CFG_KEY_LEN:  r_cfg.key_length <= i_cfg_data[rc4_pkg::KEY_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_item.data_byte        = i_s_axis_tdata;
    assign w_item.first_of_message = i_s_axis_tuser;
    assign w_item.last_of_message  = i_s_axis_tlast;

    assign o_s_axis_tready = w_idle;
    assign w_start         = i_s_axis_tvalid && w_idle;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    rc4_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_start    (w_start),
        .i_item     (w_item),
        .o_idle     (w_idle),
        .i_out_free (w_out_free),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.cipher_byte;
    assign o_m_axis_tlast  = r_out.last_out;

endmodule

// File: verif/rc4_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream checker
// Follows every register write and every input transaction, keeps its own
// copy of the RC4 state to work out the cipher byte each input must produce,
// and compares the output transactions against those bytes in order.
// ----------------------------------------------------------------------------
module rc4_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    input  logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,
    input  logic                           i_s_axis_tuser,
    input  logic                           i_s_axis_tlast,
    input  logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [7:0]                     o_m_axis_tdata,
    input  logic                           o_m_axis_tlast,
    output int                             o_mismatch_count,
    output int                             o_pending
);
    import rc4_pkg::*;

    logic [CFG_DATA_W-1:0] key_low;
    logic [CFG_DATA_W-1:0] key_high;
    logic [KEY_LEN_W-1:0]  key_len;
    logic [7:0]            sbox [SBOX_SIZE];
    logic [7:0]            ks_i;
    logic [7:0]            ks_j;
    bit                    keyed;
    t_rc4_result           cipher_q [$];
    t_rc4_result           want;
    int                    mismatches = 0;
    int                    results_seen = 0;

    assign o_mismatch_count = mismatches;

    function automatic logic [7:0] key_byte(input int k);
        logic [CFG_DATA_W-1:0] word;
        word = (k < 8) ? key_low : key_high;
        return word[(k % 8) * 8 +: 8];
    endfunction

    function automatic void schedule_key();
        int         len;
        logic [7:0] j;
        logic [7:0] t;
        len = (key_len == 0) ? 1 : ((key_len > MAX_KEY_LEN) ? MAX_KEY_LEN : int'(key_len));
        for (int n = 0; n < SBOX_SIZE; n++) begin
            sbox[n] = 8'(n);
        end
        j = 8'd0;
        for (int n = 0; n < SBOX_SIZE; n++) begin
            j = j + sbox[n] + key_byte(n % len);
            t = sbox[n];
            sbox[n] = sbox[j];
            sbox[j] = t;
        end
        ks_i = 8'd0;
        ks_j = 8'd0;
        keyed = 1'b1;
    endfunction

    function automatic logic [7:0] next_keystream();
        logic [7:0] t;
        logic [7:0] k;
        ks_i = ks_i + 8'd1;
        ks_j = ks_j + sbox[ks_i];
        t = sbox[ks_i];
        sbox[ks_i] = sbox[ks_j];
        sbox[ks_j] = t;
        k = sbox[ks_i] + sbox[ks_j];
        return sbox[k];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_low = '0;
            key_high = '0;
            key_len = KEY_LEN_RESET;
            ks_i = 8'd0;
            ks_j = 8'd0;
            keyed = 1'b0;
            cipher_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KEY_LOW: begin
                        key_low = i_cfg_data;
                    end
                    CFG_KEY_HIGH: begin
                        key_high = i_cfg_data;
                    end
                    CFG_KEY_LEN: begin
                        key_len = i_cfg_data[KEY_LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (i_s_axis_tuser || !keyed) begin
                    schedule_key();
                end
                want.cipher_byte = i_s_axis_tdata ^ next_keystream();
                want.last_out = i_s_axis_tlast;
                cipher_q.push_back(want);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (cipher_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Output %0d arrived with nothing outstanding: cipher %02h last %0b",
                                 results_seen, o_m_axis_tdata, o_m_axis_tlast);
                    end
                end else begin
                    want = cipher_q.pop_front();
                    if (want.cipher_byte !== o_m_axis_tdata || want.last_out !== o_m_axis_tlast) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Output %0d mismatch: expected cipher %02h last %0b, got %02h last %0b",
                                     results_seen, want.cipher_byte, want.last_out,
                                     o_m_axis_tdata, o_m_axis_tlast);
                        end
                    end
                end
                results_seen++;
            end
            o_pending <= cipher_q.size();
        end
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Drives register writes and byte streams into the cipher, including an
// unkeyed start, key changes mid message, out-of-range key lengths and
// register indexes, and random messages under three idle patterns; the
// checker beside the block predicts and compares every output byte.
// ----------------------------------------------------------------------------
module testbench;
    import rc4_pkg::*;

    localparam int STALL_LIMIT = 10000;
    localparam int PHASE_BYTES = 650;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = 1'b0;
    logic                  i_s_axis_tlast = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [7:0]            o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    int mismatches;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;
    int bytes_sent = 0;
    int rekey_requests = 0;
    int reg_writes = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    rc4_stream_cipher dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    rc4_checker cipher_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_s_axis_tvalid  (i_s_axis_tvalid),
        .o_s_axis_tready  (o_s_axis_tready),
        .i_s_axis_tdata   (i_s_axis_tdata),
        .i_s_axis_tuser   (i_s_axis_tuser),
        .i_s_axis_tlast   (i_s_axis_tlast),
        .o_m_axis_tvalid  (o_m_axis_tvalid),
        .i_m_axis_tready  (i_m_axis_tready),
        .o_m_axis_tdata   (o_m_axis_tdata),
        .o_m_axis_tlast   (o_m_axis_tlast),
        .o_mismatch_count (mismatches),
        .o_pending        (pending)
    );

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("No transaction for %0d cycles, %0d outputs outstanding.",
                     quiet_cycles, pending);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic first_flag,
                             input logic last_flag);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= data;
        i_s_axis_tuser <= first_flag;
        i_s_axis_tlast <= last_flag;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
        if (first_flag) begin
            rekey_requests++;
        end
    endtask

    task automatic pause_until_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
    endtask

    task automatic load_key(input logic [CFG_DATA_W-1:0] low, input logic [CFG_DATA_W-1:0] high,
                            input logic [KEY_LEN_W-1:0] len);
        pause_until_drained();
        write_reg(CFG_KEY_LOW, low);
        write_reg(CFG_KEY_HIGH, high);
        write_reg(CFG_KEY_LEN, CFG_DATA_W'(len));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_settings();
        logic [KEY_LEN_W-1:0] len;
        case ($urandom_range(9))
            0: begin
                len = '0;
            end
            1: begin
                len = KEY_LEN_W'($urandom_range(31, 17));
            end
            2: begin
                len = KEY_LEN_W'(1);
            end
            3: begin
                len = KEY_LEN_W'(MAX_KEY_LEN);
            end
            default: begin
                len = KEY_LEN_W'($urandom_range(MAX_KEY_LEN, 1));
            end
        endcase
        pause_until_drained();
        if ($urandom_range(2) != 0) begin
            write_reg(CFG_KEY_LOW, {$urandom, $urandom});
        end
        if ($urandom_range(2) != 0) begin
            write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
        end
        if ($urandom_range(5) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(255, 3)), {$urandom, $urandom});
        end
        write_reg(CFG_KEY_LEN, CFG_DATA_W'(len));
        i_cfg_valid <= 1'b0;
    endtask

    // A noisy message scatters extra first flags and sets last flags at random; a resumed one
    // carries on the keystream of the message before it.
    task automatic send_message(input int len, input bit noisy, input bit resume);
        bit is_first;
        bit is_last;
        for (int b = 0; b < len; b++) begin
            is_first = (b == 0) && !resume;
            is_last = (b == len - 1);
            if (noisy) begin
                is_first = is_first || ($urandom_range(7) == 0);
                is_last = ($urandom_range(3) == 0);
            end
            push_byte(8'($urandom_range(255)), is_first, is_last);
        end
    endtask

    initial begin
        int phase_end;
        int shape;
        int msg_len;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first byte after reset must rekey even without a first flag.
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b1);

        // A short ASCII key; its key changes halfway through the message and
        // must not take effect until the next first flag.
        load_key(64'h0000_0000_0079_654B, 64'h0, KEY_LEN_W'(3));
        push_byte(8'h50, 1'b1, 1'b0);
        push_byte(8'h6C, 1'b0, 1'b0);
        load_key('1, '1, KEY_LEN_W'(MAX_KEY_LEN));
        push_byte(8'h61, 1'b0, 1'b0);
        push_byte(8'h69, 1'b0, 1'b0);
        push_byte(8'h6E, 1'b0, 1'b1);
        push_byte(8'hA5, 1'b1, 1'b1);

        load_key({$urandom, $urandom}, '0, '0);
        push_byte(8'h3C, 1'b1, 1'b0);
        push_byte(8'hC3, 1'b0, 1'b1);

        // Writes to unused indexes are dropped; the key length saturates.
        pause_until_drained();
        write_reg(CFG_IDX_W'(3), {$urandom, $urandom});
        write_reg('1, {$urandom, $urandom});
        write_reg(CFG_KEY_LEN, CFG_DATA_W'(31));
        i_cfg_valid <= 1'b0;
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h5A, 1'b0, 1'b1);

        load_key(64'h0, {$urandom, $urandom}, KEY_LEN_W'(1));
        push_byte(8'($urandom_range(255)), 1'b1, 1'b1);

        load_key({$urandom, $urandom}, {$urandom, $urandom}, KEY_LEN_W'(MAX_KEY_LEN));
        push_byte(8'($urandom_range(255)), 1'b1, 1'b0);
        push_byte(8'($urandom_range(255)), 1'b0, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct <= 37;
                    recv_idle_pct <= 68;
                end
                1: begin
                    send_idle_pct <= 68;
                    recv_idle_pct <= 37;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            random_settings();
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) begin
                if ($urandom_range(4) == 0) begin
                    random_settings();
                end
                shape = $urandom_range(19);
                if (shape < 15) begin
                    msg_len = $urandom_range(16, 1);
                end else if (shape < 18) begin
                    msg_len = $urandom_range(80, 17);
                end else begin
                    msg_len = $urandom_range(12, 1);
                end
                send_message(msg_len, shape >= 18, shape == 19);
            end
        end

        pause_until_drained();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d bytes, %0d flagged as message starts, and %0d register writes,",
                 bytes_sent, rekey_requests, reg_writes);
        $display("under three idle patterns with key lengths 0 to 31 and mid-message key changes.");
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/rc4_pkg.sv
rtl/rc4_ram.sv
rtl/rc4_core.sv
rtl/rc4_stream_cipher.sv
verif/rc4_checker.sv
verif/testbench.sv
